FILE: rtl/positional_list_engine_defines.svh
// Assertion macros for the positional list engine checker.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH
// Implication checked every clock outside reset.
`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/ple_pkg.sv
// Shared types and codes for the positional list engine.
`default_nettype none
package ple_pkg;
  localparam int DATA_W = 32;
  localparam int POS_W = 7;
  localparam logic [3:0] OP_INS_FIRST = 4'd0;
  localparam logic [3:0] OP_INS_LAST = 4'd1;
  localparam logic [3:0] OP_INS_AT = 4'd2;
  localparam logic [3:0] OP_DEL_FIRST = 4'd3;
  localparam logic [3:0] OP_DEL_LAST = 4'd4;
  localparam logic [3:0] OP_DEL_AT = 4'd5;
  localparam logic [3:0] OP_FIND_FIRST = 4'd6;
  localparam logic [3:0] OP_FIND_LAST = 4'd7;
  localparam logic [3:0] OP_COUNT = 4'd8;
  localparam logic [3:0] OP_LENGTH = 4'd9;
  localparam logic [3:0] OP_REVERSE = 4'd10;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;
endpackage
`default_nettype wire

FILE: rtl/positional_list_engine.sv
// Top level: list sequencer around one RAM holding the list entries.
// Length, unused codes, rejects and searches of an empty list skip the RAM and go straight
// to the output; inserts and deletes shift entries, searches read every entry, and reverse
// swaps pairs of entries from both ends when the length is at least 2.
// One item at a time: the next input transfer can come in the cycle after the output transfer.
// Synchronous active-low reset clears the length and control; RAM is not cleared.
`default_nettype none
module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // opcode[3:0], item_value[35:4], position[42:36]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata  // result_value[31:0], status[33:32]
);
  import ple_pkg::*;
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_RUN = 5'b00010, S_REV = 5'b00100,
    S_DONE = 5'b01000, S_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [3:0] op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt, res_r, res_nxt;
  logic [1:0] st_r, st_nxt;
  logic [LW-1:0] i_r, i_nxt, j_r, j_nxt, end_r, end_nxt;
  logic rd_ok_r, rd_ok_nxt, phase_r, phase_nxt;
  logic [DATA_W-1:0] hold_r, hold_nxt;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  logic [LW-1:0] ridx_r, ridx_nxt;

  ple_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  wire [3:0] in_op = in_tdata[3:0];
  wire [DATA_W-1:0] in_val = in_tdata[35:4];
  wire [LW:0] in_pos = (LW+1)'(in_tdata[42:36]);
  wire [LW:0] len_x = (LW+1)'(len_r);
  wire full = (len_r == LW'(CAPACITY));

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {6'd0, st_r, res_r};

  // Shift modes: insert moves entries up with j_r walking down from len to i_r;
  // delete moves down walking up. Search reads 0..len-1.
  always_comb begin
    state_nxt = state_r; len_nxt = len_r; op_nxt = op_r; val_nxt = val_r;
    res_nxt = res_r; st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; end_nxt = end_r;
    rd_ok_nxt = 1'b0; phase_nxt = phase_r; hold_nxt = hold_r; ridx_nxt = ridx_r;
    we = 1'b0; waddr = AW'(i_r); wdata = val_r; raddr = AW'(i_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_op; val_nxt = in_val; res_nxt = '0; st_nxt = ST_OK;
          state_nxt = S_DONE;
          case (in_op) inside
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
              if (in_op == OP_INS_AT && (in_pos == 0 || in_pos > len_x + 1))
                st_nxt = ST_BADPOS;
              else if (full) st_nxt = ST_FULL;
              else begin
                // target index in i, walk j from len down to i
                i_nxt = (in_op == OP_INS_FIRST) ? '0 :
                        (in_op == OP_INS_LAST) ? len_r : LW'(in_pos - 1);
                j_nxt = len_r;
                ridx_nxt = len_r;
                state_nxt = S_RUN;
              end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
              if (in_op != OP_DEL_AT && len_r == 0) begin
                res_nxt = '1; st_nxt = ST_EMPTY;
              end else if (in_op == OP_DEL_AT && (in_pos == 0 || in_pos > len_x)) begin
                res_nxt = '1; st_nxt = ST_BADPOS;
              end else begin
                i_nxt = (in_op == OP_DEL_FIRST) ? '0 :
                        (in_op == OP_DEL_LAST) ? LW'(len_r - 1) : LW'(in_pos - 1);
                j_nxt = (in_op == OP_DEL_FIRST) ? '0 :
                        (in_op == OP_DEL_LAST) ? LW'(len_r - 1) : LW'(in_pos - 1);
                ridx_nxt = j_nxt;
                state_nxt = S_RUN;
              end
            end
            OP_FIND_FIRST, OP_FIND_LAST, OP_COUNT: begin
              j_nxt = '0; ridx_nxt = '0;
              if (len_r != 0) state_nxt = S_RUN;
            end
            OP_LENGTH: res_nxt = DATA_W'(len_r);
            OP_REVERSE: begin
              j_nxt = '0; end_nxt = LW'(len_r - 1); phase_nxt = 1'b0; ridx_nxt = '0;
              if (len_r > 1) state_nxt = S_REV;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        // ridx_r is issued this cycle; rdata returns for the previous issue
        raddr = AW'(ridx_r);
        case (op_r) inside
          OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
            // j_r: slot being written. Need entry j-1 when j > i.
            if (j_r == i_r) begin
              we = 1'b1; waddr = AW'(i_r); wdata = val_r;
              len_nxt = len_r + 1'b1; state_nxt = S_DONE;
            end else if (!rd_ok_r) begin
              raddr = AW'(j_r - 1'b1); rd_ok_nxt = 1'b1;
            end else begin
              we = 1'b1; waddr = AW'(j_r); wdata = rdata;
              j_nxt = j_r - 1'b1;
              if (j_r - 1'b1 != i_r) begin
                raddr = AW'(j_r - 2'd2); rd_ok_nxt = 1'b1;
              end
            end
          end
          OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
            // read entry j, first read gives the removed value, then j+1 -> j
            if (!rd_ok_r) begin
              raddr = AW'(j_r); rd_ok_nxt = 1'b1; phase_nxt = 1'b0;
            end else begin
              if (!phase_r) res_nxt = rdata;
              else begin
                we = 1'b1; waddr = AW'(j_r - 1'b1); wdata = rdata;
              end
              phase_nxt = 1'b1;
              if ((LW+1)'(j_r) + 1 < len_x) begin
                raddr = AW'(j_r + 1'b1); j_nxt = j_r + 1'b1; rd_ok_nxt = 1'b1;
              end else begin
                len_nxt = len_r - 1'b1; state_nxt = S_DONE;
              end
            end
          end
          default: begin
            // searches: j_r issued index, i_r index of returned data
            if (rd_ok_r) begin
              if (rdata == val_r) begin
                if (op_r == OP_COUNT) res_nxt = res_r + 1'b1;
                else if (op_r == OP_FIND_LAST || res_r == 0)
                  res_nxt = DATA_W'(i_r) + 1'b1;
              end
            end
            if (rd_ok_r && (LW+1)'(i_r) + 1 >= len_x) state_nxt = S_DONE;
            else begin
              raddr = AW'(j_r);
              if ((LW+1)'(j_r) < len_x) begin
                rd_ok_nxt = 1'b1; j_nxt = j_r + 1'b1; i_nxt = j_r;
              end
            end
          end
        endcase
      end
      S_REV: begin
        // read low, read high, write high value low, write held low value high
        if (!phase_r) begin
          if (!rd_ok_r) begin
            raddr = AW'(j_r); rd_ok_nxt = 1'b1;
          end else begin
            hold_nxt = rdata; raddr = AW'(end_r); rd_ok_nxt = 1'b1; phase_nxt = 1'b1;
          end
        end else if (rd_ok_r) begin
          we = 1'b1; waddr = AW'(j_r); wdata = rdata;
        end else begin
          we = 1'b1; waddr = AW'(end_r); wdata = hold_r; phase_nxt = 1'b0;
          if ((LW+1)'(j_r) + 2 >= (LW+1)'(end_r)) state_nxt = S_DONE;
          else begin
            // advance to the next pair and issue its low read
            j_nxt = j_r + 1'b1; end_nxt = end_r - 1'b1;
            raddr = AW'(j_r + 1'b1); rd_ok_nxt = 1'b1;
          end
        end
      end
      S_DONE: state_nxt = S_OUT;
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; len_r <= '0; rd_ok_r <= 1'b0; phase_r <= 1'b0;
      i_r <= '0;
    end else begin
      state_r <= state_nxt; len_r <= len_nxt; rd_ok_r <= rd_ok_nxt;
      phase_r <= phase_nxt; i_r <= i_nxt;
    end
    op_r <= op_nxt; val_r <= val_nxt; res_r <= res_nxt; st_r <= st_nxt;
    j_r <= j_nxt; end_r <= end_nxt; hold_r <= hold_nxt; ridx_r <= ridx_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/ple_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/ple_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
`default_nettype none
`include "positional_list_engine_defines.svh"
module ple_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  `PLE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `PLE_ASSERT_IMP(a_busy_when_out, clk, rst_n, out_tvalid, !in_tready)
  `PLE_ASSERT_NXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `PLE_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[39:34] == 6'd0)
endmodule
bind positional_list_engine ple_port_checker u_ple_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
